// ===== hw/rtl/ialloc_pkg.sv =====
// Shared types and codes for the slot index allocator.
// Holds the request and response structs, the controller/datapath command and
// status structs, and the selector codes. No dependencies.
package ialloc_pkg;

	localparam int FREE_DEPTH_DEF = 1024;
	localparam int INDEX_BITS_DEF = 16;
	localparam int MAX_RUN_DEF    = 64;

	// request modes
	localparam logic [2:0] MODE_ALLOC_ONE = 3'd0;
	localparam logic [2:0] MODE_FREE_ONE  = 3'd1;
	localparam logic [2:0] MODE_ALLOC_RUN = 3'd2;
	localparam logic [2:0] MODE_FREE_RUN  = 3'd3;
	localparam logic [2:0] MODE_CONTAINS  = 3'd4;
	localparam logic [2:0] MODE_CLEAR     = 3'd5;

	// response status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_RANGE     = 3'd2;
	localparam logic [2:0] ST_LIST_FULL = 3'd3;
	localparam logic [2:0] ST_DUP       = 3'd4;

	// read address select
	localparam logic [1:0] RA_FEM1 = 2'd0;
	localparam logic [1:0] RA_I    = 2'd1;
	localparam logic [1:0] RA_JM1  = 2'd2;

	// write address select
	localparam logic WA_FE = 1'b0;
	localparam logic WA_J  = 1'b1;

	// write data select
	localparam logic [1:0] WD_SIDX = 2'd0;
	localparam logic [1:0] WD_APP  = 2'd1;
	localparam logic [1:0] WD_RD   = 2'd2;
	localparam logic [1:0] WD_V    = 2'd3;

	// free entry count operations
	localparam logic [2:0] FE_NONE    = 3'd0;
	localparam logic [2:0] FE_INC     = 3'd1;
	localparam logic [2:0] FE_DEC     = 3'd2;
	localparam logic [2:0] FE_SUB_LEN = 3'd3;
	localparam logic [2:0] FE_CLR     = 3'd4;

	// high-water count operations
	localparam logic [2:0] HW_NONE    = 3'd0;
	localparam logic [2:0] HW_INC     = 3'd1;
	localparam logic [2:0] HW_DEC     = 3'd2;
	localparam logic [2:0] HW_ADD_LEN = 3'd3;
	localparam logic [2:0] HW_CLR     = 3'd4;

	// scan pointer operations
	localparam logic [1:0] I_NONE = 2'd0;
	localparam logic [1:0] I_ZERO = 2'd1;
	localparam logic [1:0] I_ONE  = 2'd2;
	localparam logic [1:0] I_INC  = 2'd3;

	localparam logic [2:0] J_NONE   = 3'd0;
	localparam logic [2:0] J_COPY_I = 3'd1;
	localparam logic [2:0] J_DEC    = 3'd2;
	localparam logic [2:0] J_INC    = 3'd3;
	localparam logic [2:0] J_FIRST  = 3'd4;

	localparam logic [1:0] K_NONE = 2'd0;
	localparam logic [1:0] K_ZERO = 2'd1;
	localparam logic [1:0] K_INC  = 2'd2;

	// result index / length select
	localparam logic [1:0] IS_ZERO  = 2'd0;
	localparam logic [1:0] IS_HW    = 2'd1;
	localparam logic [1:0] IS_RD    = 2'd2;
	localparam logic [1:0] IS_START = 2'd3;

	localparam logic [1:0] LS_ZERO = 2'd0;
	localparam logic [1:0] LS_ONE  = 2'd1;
	localparam logic [1:0] LS_LEN  = 2'd2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] slot_index;
		logic [6:0]  run_length;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] granted_index;
		logic [6:0]  granted_length;
		logic        present;
	} rsp_t;

	typedef struct packed {
		logic       latch;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       wr_en;
		logic       wr_asel;
		logic [1:0] wr_dsel;
		logic [2:0] fe_op;
		logic [2:0] hw_op;
		logic [1:0] i_op;
		logic [2:0] j_op;
		logic [1:0] k_op;
		logic       v_load;
		logic       scan_clr;
		logic       scan_upd;
		logic       res_set;
		logic [2:0] res_status;
		logic [1:0] res_isel;
		logic [1:0] res_lsel;
		logic       res_present;
		logic       publish;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       len_ok;
		logic       fe_zero;
		logic       fe_full;
		logic       fe_room;
		logic       hw_full;
		logic       hw_zero;
		logic       run_fits;
		logic       sidx_ge_hw;
		logic       sidx_zero;
		logic       i_eq_fe;
		logic       i_ge_fe;
		logic       j_zero;
		logic       app_in;
		logic       app_last;
		logic       dup;
		logic       hit;
		logic       rd_gt_v;
		logic       rd_ge_hw;
		logic       rd_eq_hwm1;
		logic       rd_eq_sidx;
		logic       out_free;
	} st_t;

endpackage

// ===== hw/rtl/ialloc_dp.sv =====
// Datapath of the slot index allocator: counts, scan pointers, free store
// memory and the response register. Depends on ialloc_pkg.
module ialloc_dp #(
	parameter int FREE_DEPTH = 1024,
	parameter int INDEX_BITS = 16,
	parameter int MAX_RUN    = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ialloc_pkg::req_t  req,
	input  ialloc_pkg::cmd_t  cmd,
	output ialloc_pkg::st_t   st,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ialloc_pkg::rsp_t  rsp
);
	import ialloc_pkg::*;

	localparam int AW   = $clog2(FREE_DEPTH);
	localparam int FW   = $clog2(FREE_DEPTH + 1);
	localparam int HWW  = INDEX_BITS + 1;
	localparam int CW   = (HWW > 17) ? HWW : 17;
	localparam logic [CW-1:0] SPACE_C = CW'(1) << INDEX_BITS;
	localparam logic [FW-1:0] DEPTH_C = FW'(FREE_DEPTH);

	req_t                  req_q;
	logic [HWW-1:0]        hw_q;
	logic [FW-1:0]         fe_q, i_q, j_q;
	logic [6:0]            k_q, cnt_q;
	logic [INDEX_BITS-1:0] v_q, start_q, rd_q;
	logic                  have_q;
	logic [2:0]            res_status_q;
	logic [15:0]           res_index_q;
	logic [6:0]            res_length_q;
	logic                  res_present_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [INDEX_BITS-1:0] mem [FREE_DEPTH];

	logic [CW-1:0] sidx_c, hw_c, rd_c, len_c, start_c, cnt_c, app_v;
	logic [FW-1:0] ra_full, wa_full;
	logic [INDEX_BITS-1:0] wd;
	logic [INDEX_BITS-1:0] s_next;
	logic [6:0] c_next;
	logic dup;

	assign sidx_c  = CW'(req_q.slot_index);
	assign hw_c    = CW'(hw_q);
	assign rd_c    = CW'(rd_q);
	assign len_c   = CW'(req_q.run_length);
	assign start_c = CW'(start_q);
	assign cnt_c   = CW'(cnt_q);
	assign app_v   = sidx_c + CW'(k_q);

	// run scan step
	always_comb begin
		s_next = start_q;
		c_next = cnt_q;
		dup    = 1'b0;
		if (!have_q) begin
			s_next = rd_q;
			c_next = 7'd1;
		end else if (rd_c == start_c + cnt_c) begin
			c_next = cnt_q + 7'd1;
		end else if (rd_c == start_c + cnt_c - CW'(1)) begin
			dup = 1'b1;
		end else begin
			s_next = rd_q;
			c_next = 7'd1;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RA_FEM1: ra_full = fe_q - FW'(1);
			RA_I:    ra_full = i_q;
			RA_JM1:  ra_full = j_q - FW'(1);
			default: ra_full = i_q;
		endcase
		wa_full = (cmd.wr_asel == WA_J) ? j_q : fe_q;
		case (cmd.wr_dsel)
			WD_SIDX: wd = INDEX_BITS'(req_q.slot_index);
			WD_APP:  wd = app_v[INDEX_BITS-1:0];
			WD_RD:   wd = rd_q;
			WD_V:    wd = v_q;
			default: wd = rd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[wa_full[AW-1:0]] <= wd;
		if (cmd.rd_en)
			rd_q <= mem[ra_full[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q        <= '0;
			fe_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (cmd.fe_op)
				FE_INC:     fe_q <= fe_q + FW'(1);
				FE_DEC:     fe_q <= fe_q - FW'(1);
				FE_SUB_LEN: fe_q <= fe_q - FW'(req_q.run_length);
				FE_CLR:     fe_q <= '0;
				default:    fe_q <= fe_q;
			endcase
			case (cmd.hw_op)
				HW_INC:     hw_q <= hw_q + HWW'(1);
				HW_DEC:     hw_q <= hw_q - HWW'(1);
				HW_ADD_LEN: hw_q <= hw_q + HWW'(req_q.run_length);
				HW_CLR:     hw_q <= '0;
				default:    hw_q <= hw_q;
			endcase
			if (cmd.publish)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q         <= req;
			res_status_q  <= ST_OK;
			res_index_q   <= '0;
			res_length_q  <= '0;
			res_present_q <= 1'b0;
		end
		if (cmd.res_set) begin
			res_status_q  <= cmd.res_status;
			res_present_q <= cmd.res_present;
			case (cmd.res_isel)
				IS_HW:    res_index_q <= 16'(hw_q);
				IS_RD:    res_index_q <= 16'(rd_q);
				IS_START: res_index_q <= 16'(s_next);
				default:  res_index_q <= '0;
			endcase
			case (cmd.res_lsel)
				LS_ONE:  res_length_q <= 7'd1;
				LS_LEN:  res_length_q <= req_q.run_length;
				default: res_length_q <= '0;
			endcase
		end
		if (cmd.publish) begin
			rsp_q.status         <= res_status_q;
			rsp_q.granted_index  <= res_index_q;
			rsp_q.granted_length <= res_length_q;
			rsp_q.present        <= res_present_q;
		end
		case (cmd.i_op)
			I_ZERO:  i_q <= '0;
			I_ONE:   i_q <= FW'(1);
			I_INC:   i_q <= i_q + FW'(1);
			default: i_q <= i_q;
		endcase
		case (cmd.j_op)
			J_COPY_I: j_q <= i_q;
			J_DEC:    j_q <= j_q - FW'(1);
			J_INC:    j_q <= j_q + FW'(1);
			J_FIRST:  j_q <= i_q + FW'(1) - FW'(req_q.run_length);
			default:  j_q <= j_q;
		endcase
		case (cmd.k_op)
			K_ZERO:  k_q <= '0;
			K_INC:   k_q <= k_q + 7'd1;
			default: k_q <= k_q;
		endcase
		if (cmd.v_load)
			v_q <= rd_q;
		if (cmd.scan_clr)
			have_q <= 1'b0;
		else if (cmd.scan_upd) begin
			have_q  <= 1'b1;
			start_q <= s_next;
			cnt_q   <= c_next;
		end
	end

	always_comb begin
		st.mode       = req_q.mode;
		st.len_ok     = (req_q.run_length != 7'd0) &&
		                ({25'd0, req_q.run_length} <= 32'(MAX_RUN));
		st.fe_zero    = (fe_q == '0);
		st.fe_full    = (fe_q >= DEPTH_C);
		st.fe_room    = (32'(fe_q) + 32'(req_q.run_length)) <= 32'(FREE_DEPTH);
		st.hw_full    = (hw_c >= SPACE_C);
		st.hw_zero    = (hw_q == '0);
		st.run_fits   = (hw_c + len_c) <= SPACE_C;
		st.sidx_ge_hw = (sidx_c >= hw_c);
		st.sidx_zero  = (req_q.slot_index == 16'd0);
		st.i_eq_fe    = (i_q == fe_q);
		st.i_ge_fe    = (i_q >= fe_q);
		st.j_zero     = (j_q == '0);
		st.app_in     = (app_v < hw_c);
		st.app_last   = (k_q == req_q.run_length - 7'd1);
		st.dup        = dup;
		st.hit        = !dup && (c_next == req_q.run_length);
		st.rd_gt_v    = (rd_q > v_q);
		st.rd_ge_hw   = (rd_c >= hw_c);
		st.rd_eq_hwm1 = (rd_c == hw_c - CW'(1));
		st.rd_eq_sidx = (rd_c == sidx_c);
		st.out_free   = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/ialloc_ctrl.sv =====
// Controller of the slot index allocator: sequences each request over the
// datapath. Depends on ialloc_pkg.
module ialloc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  ialloc_pkg::st_t  st,
	output ialloc_pkg::cmd_t cmd
);
	import ialloc_pkg::*;

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DISP     = 5'd1;
	localparam logic [4:0] S_A1       = 5'd2;
	localparam logic [4:0] S_SCAN_RD  = 5'd3;
	localparam logic [4:0] S_SCAN_USE = 5'd4;
	localparam logic [4:0] S_MOVE_RD  = 5'd5;
	localparam logic [4:0] S_MOVE_WR  = 5'd6;
	localparam logic [4:0] S_APPEND   = 5'd7;
	localparam logic [4:0] S_SORT_I   = 5'd8;
	localparam logic [4:0] S_SORT_V   = 5'd9;
	localparam logic [4:0] S_SORT_J   = 5'd10;
	localparam logic [4:0] S_SORT_C   = 5'd11;
	localparam logic [4:0] S_TRIM_RD  = 5'd12;
	localparam logic [4:0] S_TRIM_C   = 5'd13;
	localparam logic [4:0] S_RET_RD   = 5'd14;
	localparam logic [4:0] S_RET_C    = 5'd15;
	localparam logic [4:0] S_CONT_RD  = 5'd16;
	localparam logic [4:0] S_CONT_C   = 5'd17;
	localparam logic [4:0] S_FIN      = 5'd18;

	logic [4:0] state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_FIN;
				case (st.mode)
					MODE_ALLOC_ONE: begin
						if (!st.fe_zero) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_FEM1;
							state_d    = S_A1;
						end else if (!st.hw_full) begin
							cmd.res_set  = 1'b1;
							cmd.res_isel = IS_HW;
							cmd.res_lsel = LS_ONE;
							cmd.hw_op    = HW_INC;
						end else begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_FULL;
						end
					end
					MODE_FREE_ONE: begin
						if (st.sidx_ge_hw) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_RANGE;
						end else if (st.fe_full) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_LIST_FULL;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_asel = WA_FE;
							cmd.wr_dsel = WD_SIDX;
							cmd.fe_op   = FE_INC;
						end
					end
					MODE_ALLOC_RUN: begin
						if (!st.len_ok) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_RANGE;
						end else begin
							cmd.i_op     = I_ZERO;
							cmd.scan_clr = 1'b1;
							state_d      = S_SCAN_RD;
						end
					end
					MODE_FREE_RUN: begin
						if (!st.len_ok) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_RANGE;
						end else if (!st.fe_room) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_LIST_FULL;
						end else begin
							cmd.k_op = K_ZERO;
							state_d  = S_APPEND;
						end
					end
					MODE_CONTAINS: begin
						if (!(st.sidx_zero || st.sidx_ge_hw)) begin
							cmd.i_op = I_ZERO;
							state_d  = S_CONT_RD;
						end
					end
					MODE_CLEAR: begin
						cmd.fe_op = FE_CLR;
						cmd.hw_op = HW_CLR;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_A1: begin
				cmd.res_set  = 1'b1;
				cmd.res_isel = IS_RD;
				cmd.res_lsel = LS_ONE;
				cmd.fe_op    = FE_DEC;
				state_d      = S_FIN;
			end
			S_SCAN_RD: begin
				if (st.i_eq_fe) begin
					cmd.res_set = 1'b1;
					if (st.run_fits) begin
						cmd.res_isel = IS_HW;
						cmd.res_lsel = LS_LEN;
						cmd.hw_op    = HW_ADD_LEN;
					end else begin
						cmd.res_status = ST_FULL;
					end
					state_d = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_I;
					state_d    = S_SCAN_USE;
				end
			end
			S_SCAN_USE: begin
				if (st.dup) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_DUP;
					state_d        = S_FIN;
				end else if (st.hit) begin
					cmd.res_set  = 1'b1;
					cmd.res_isel = IS_START;
					cmd.res_lsel = LS_LEN;
					cmd.j_op     = J_FIRST;
					cmd.i_op     = I_INC;
					state_d      = S_MOVE_RD;
				end else begin
					cmd.scan_upd = 1'b1;
					cmd.i_op     = I_INC;
					state_d      = S_SCAN_RD;
				end
			end
			S_MOVE_RD: begin
				if (st.i_eq_fe) begin
					cmd.fe_op = FE_SUB_LEN;
					state_d   = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_I;
					state_d    = S_MOVE_WR;
				end
			end
			S_MOVE_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_asel = WA_J;
				cmd.wr_dsel = WD_RD;
				cmd.i_op    = I_INC;
				cmd.j_op    = J_INC;
				state_d     = S_MOVE_RD;
			end
			S_APPEND: begin
				if (st.app_in) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_asel = WA_FE;
					cmd.wr_dsel = WD_APP;
					cmd.fe_op   = FE_INC;
				end
				cmd.k_op = K_INC;
				if (st.app_last) begin
					cmd.i_op = I_ONE;
					state_d  = S_SORT_I;
				end
			end
			S_SORT_I: begin
				if (st.i_ge_fe) begin
					state_d = S_TRIM_RD;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_I;
					state_d    = S_SORT_V;
				end
			end
			S_SORT_V: begin
				cmd.v_load = 1'b1;
				cmd.j_op   = J_COPY_I;
				state_d    = S_SORT_J;
			end
			S_SORT_J: begin
				if (st.j_zero) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_asel = WA_J;
					cmd.wr_dsel = WD_V;
					cmd.i_op    = I_INC;
					state_d     = S_SORT_I;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_JM1;
					state_d    = S_SORT_C;
				end
			end
			S_SORT_C: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_asel = WA_J;
				if (st.rd_gt_v) begin
					cmd.wr_dsel = WD_RD;
					cmd.j_op    = J_DEC;
					state_d     = S_SORT_J;
				end else begin
					cmd.wr_dsel = WD_V;
					cmd.i_op    = I_INC;
					state_d     = S_SORT_I;
				end
			end
			S_TRIM_RD: begin
				if (st.fe_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_FEM1;
					state_d    = S_TRIM_C;
				end
			end
			S_TRIM_C: begin
				if (st.rd_ge_hw) begin
					cmd.fe_op = FE_DEC;
					state_d   = S_TRIM_RD;
				end else begin
					state_d = S_RET_RD;
				end
			end
			S_RET_RD: begin
				if (st.fe_zero || st.hw_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_FEM1;
					state_d    = S_RET_C;
				end
			end
			S_RET_C: begin
				if (st.rd_eq_hwm1) begin
					cmd.hw_op = HW_DEC;
					cmd.fe_op = FE_DEC;
					state_d   = S_RET_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_CONT_RD: begin
				if (st.i_eq_fe) begin
					cmd.res_set     = 1'b1;
					cmd.res_present = 1'b1;
					state_d         = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_I;
					state_d    = S_CONT_C;
				end
			end
			S_CONT_C: begin
				if (st.rd_eq_sidx) begin
					state_d = S_FIN;
				end else begin
					cmd.i_op = I_INC;
					state_d  = S_CONT_RD;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/index_allocator_with_run_free_list.sv =====
// Slot index allocator with a high-water count and a run-capable free list.
// Flow: single alloc/free/clear are settled at dispatch (alloc from the list adds
// one store read); contains and run alloc scan the free entries one by one, and a
// run alloc then moves the later entries down to close the gap; run free appends
// the run's entries below the high-water count, insertion-sorts the free list,
// then trims entries at or above the high-water count and retracts the tail.
// Throughput: one request in flight; a new request is accepted only once the last
// result has been published, and a held response stalls the input.
// Reset: counts and state machine clear at once; the store is left unwritten.
module index_allocator_with_run_free_list #(
	parameter int FREE_DEPTH = ialloc_pkg::FREE_DEPTH_DEF,
	parameter int INDEX_BITS = ialloc_pkg::INDEX_BITS_DEF,
	parameter int MAX_RUN    = ialloc_pkg::MAX_RUN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  ialloc_pkg::req_t req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output ialloc_pkg::rsp_t rsp
);
	import ialloc_pkg::*;

	cmd_t cmd;
	st_t  st;

	// Sequence each transaction: dispatch on mode, walk the store as needed,
	// then hold the result until the response register is free.
	ialloc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Hold counts, pointers, the free store and the response register.
	ialloc_dp #(
		.FREE_DEPTH (FREE_DEPTH),
		.INDEX_BITS (INDEX_BITS),
		.MAX_RUN    (MAX_RUN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// one transaction at a time: no second accept right after one
	a_single_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while busy");

	// capture the request exactly on acceptance
	a_latch_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch == (req_valid && req_ready))
		else $error("request capture out of step with handshake");

	// never overwrite a response that has not been taken
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!rsp_valid || rsp_ready))
		else $error("response overwritten before transfer");

endmodule

// ===== sim/index_allocator_with_run_free_list_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the slot index allocator.
// Depends on ialloc_pkg and index_allocator_with_run_free_list; predicts each
// response in-line and compares it field by field.
module index_allocator_with_run_free_list_tb;
	import ialloc_pkg::*;

	localparam int DEPTH    = FREE_DEPTH_DEF;
	localparam int RUN_MAX  = MAX_RUN_DEF;
	localparam int SPACE    = 1 << INDEX_BITS_DEF;
	localparam logic [2:0] MODE_BAD6 = 3'd6;
	localparam logic [2:0] MODE_BAD7 = 3'd7;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// predictor copy of the allocator state
	int unsigned pool_hw;
	int unsigned pool_cnt;
	int unsigned pool[DEPTH];

	rsp_t expected_rsp_q[$];
	int   mismatch_count;
	int   sender_idle_pct;
	int   receiver_stall_pct;
	bit   hold_receiver;

	index_allocator_with_run_free_list u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Compute the response to one request and advance the predicted state.
	function automatic rsp_t predict_allocation(req_t r);
		rsp_t o;
		int unsigned len;
		int unsigned sidx;
		int unsigned i;
		int unsigned k;
		int unsigned v;
		int unsigned start;
		int unsigned cnt;
		int unsigned first;
		bit have;
		bit done;
		o = '0;
		len = 32'(r.run_length);
		sidx = 32'(r.slot_index);
		done = 1'b0;
		case (r.mode)
			MODE_ALLOC_ONE: begin
				if (pool_cnt > 0) begin
					pool_cnt--;
					o.granted_index = pool[pool_cnt][15:0];
					o.granted_length = 7'd1;
				end else if (pool_hw < SPACE) begin
					o.granted_index = pool_hw[15:0];
					o.granted_length = 7'd1;
					pool_hw++;
				end else begin
					o.status = ST_FULL;
				end
			end
			MODE_FREE_ONE: begin
				if (sidx >= pool_hw) begin
					o.status = ST_RANGE;
				end else if (pool_cnt >= DEPTH) begin
					o.status = ST_LIST_FULL;
				end else begin
					pool[pool_cnt] = sidx;
					pool_cnt++;
				end
			end
			MODE_ALLOC_RUN: begin
				if (len < 1 || len > RUN_MAX) begin
					o.status = ST_RANGE;
				end else begin
					have = 1'b0;
					start = 0;
					cnt = 0;
					for (i = 0; i < pool_cnt && !done; i++) begin
						v = pool[i];
						if (!have) begin
							have = 1'b1;
							start = v;
							cnt = 1;
						end else if (v == start + cnt) begin
							cnt++;
						end else if (v == start + cnt - 1) begin
							o.status = ST_DUP;
							done = 1'b1;
						end else begin
							start = v;
							cnt = 1;
						end
						if (!done && cnt == len) begin
							first = i + 1 - cnt;
							for (k = i + 1; k < pool_cnt; k++)
								pool[first + k - i - 1] = pool[k];
							pool_cnt -= cnt;
							o.granted_index = start[15:0];
							o.granted_length = cnt[6:0];
							done = 1'b1;
						end
					end
					if (!done) begin
						if (pool_hw + len > SPACE) begin
							o.status = ST_FULL;
						end else begin
							o.granted_index = pool_hw[15:0];
							o.granted_length = len[6:0];
							pool_hw += len;
						end
					end
				end
			end
			MODE_FREE_RUN: begin
				if (len < 1 || len > RUN_MAX) begin
					o.status = ST_RANGE;
				end else if (pool_cnt + len > DEPTH) begin
					o.status = ST_LIST_FULL;
				end else begin
					for (k = 0; k < len; k++) begin
						v = sidx + k;
						if (v < pool_hw) begin
							pool[pool_cnt] = v;
							pool_cnt++;
						end
					end
					// insertion sort, ascending
					for (i = 1; i < pool_cnt; i++) begin
						v = pool[i];
						k = i;
						while (k > 0 && pool[k - 1] > v) begin
							pool[k] = pool[k - 1];
							k--;
						end
						pool[k] = v;
					end
					while (pool_cnt > 0 && pool[pool_cnt - 1] >= pool_hw)
						pool_cnt--;
					while (pool_hw > 0 && pool_cnt > 0 && pool[pool_cnt - 1] == pool_hw - 1) begin
						pool_hw--;
						pool_cnt--;
					end
				end
			end
			MODE_CONTAINS: begin
				o.present = 1'b1;
				if (sidx == 0 || sidx >= pool_hw) begin
					o.present = 1'b0;
				end else begin
					for (i = 0; i < pool_cnt; i++)
						if (pool[i] == sidx)
							o.present = 1'b0;
				end
			end
			MODE_CLEAR: begin
				pool_hw = 0;
				pool_cnt = 0;
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		mismatch_count++;
	endtask

	// Offer one transaction and hold it until accepted; valid stays up so the
	// next call can follow back to back, and drops when the sender idles.
	task automatic send_request(logic [2:0] m, logic [15:0] s, logic [6:0] l);
		req_t r;
		r.mode = m;
		r.slot_index = s;
		r.run_length = l;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		expected_rsp_q.push_back(predict_allocation(r));
		@(negedge clk);
	endtask

	// Drop valid and wait for every outstanding response.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Receiver stall pattern, plus a long hold when asked.
	always @(negedge clk) begin
		if (!arst_n)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= !hold_receiver && ($urandom_range(99) >= receiver_stall_pct);
	end

	// Check each response transaction against the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp_q.size() == 0) begin
				report_mismatch("unexpected response, queue depth", 0, 1);
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", int'(rsp.status), int'(want.status));
				if (rsp.granted_index !== want.granted_index)
					report_mismatch("granted_index", int'(rsp.granted_index),
						int'(want.granted_index));
				if (rsp.granted_length !== want.granted_length)
					report_mismatch("granted_length", int'(rsp.granted_length),
						int'(want.granted_length));
				if (rsp.present !== want.present)
					report_mismatch("present", int'(rsp.present), int'(want.present));
			end
		end
	end

	// Hit every mode, the field extremes and the named corner cases.
	task automatic test_directed();
		send_request(MODE_ALLOC_ONE, 16'd0, 7'd0);
		send_request(MODE_FREE_ONE, 16'hFFFF, 7'd1);      // out of range
		send_request(MODE_ALLOC_RUN, 16'd0, 7'd0);        // bad length
		send_request(MODE_ALLOC_RUN, 16'd0, 7'd127);
		send_request(MODE_ALLOC_RUN, 16'd0, 7'd64);
		send_request(MODE_CONTAINS, 16'd0, 7'd0);         // index zero never present
		send_request(MODE_CONTAINS, 16'd5, 7'd0);
		send_request(MODE_FREE_ONE, 16'd5, 7'd0);
		send_request(MODE_FREE_ONE, 16'd5, 7'd0);         // duplicate appended
		send_request(MODE_CONTAINS, 16'd5, 7'd0);
		send_request(MODE_FREE_RUN, 16'd10, 7'd4);
		send_request(MODE_ALLOC_RUN, 16'd0, 7'd2);        // duplicate seen in scan
		send_request(MODE_FREE_RUN, 16'd60, 7'd64);       // tail retract, above hw
		send_request(MODE_ALLOC_ONE, 16'd0, 7'd0);
		send_request(MODE_FREE_RUN, 16'd0, 7'd0);
		send_request(MODE_BAD6, 16'hFFFF, 7'h7F);
		send_request(MODE_BAD7, 16'h5555, 7'h2A);
		send_request(MODE_CLEAR, 16'h0000, 7'd0);
		send_request(MODE_FREE_ONE, 16'd0, 7'd0);
	endtask

	// Fill the free list to depth with run frees to reach the list-full status.
	task automatic test_free_list_full();
		int n;
		send_request(MODE_ALLOC_RUN, 16'd0, 7'd64);
		for (n = 0; n < 16; n++)
			send_request(MODE_FREE_RUN, 16'd0, 7'd63);
		send_request(MODE_FREE_RUN, 16'd0, 7'd16);
		send_request(MODE_FREE_ONE, 16'd1, 7'd0);
		send_request(MODE_FREE_RUN, 16'd1, 7'd1);
		send_request(MODE_CLEAR, 16'd0, 7'd0);
	endtask

	// Mostly well-formed traffic on a small index window with random content.
	task automatic test_random(int count);
		int n;
		int sel;
		logic [15:0] s;
		for (n = 0; n < count; n++) begin
			sel = $urandom_range(99);
			s = (pool_hw > 0) ? 16'($urandom_range(pool_hw + 2)) : 16'($urandom_range(3));
			if (sel < 2)
				send_request(3'($urandom_range(7)), 16'($urandom), 7'($urandom));
			else if (sel < 20)
				send_request(MODE_ALLOC_ONE, 16'($urandom), 7'($urandom));
			else if (sel < 40)
				send_request(MODE_FREE_ONE, s, 7'($urandom));
			else if (sel < 58)
				send_request(MODE_ALLOC_RUN, 16'($urandom), 7'($urandom_range(1, 12)));
			else if (sel < 75)
				send_request(MODE_FREE_RUN, s, 7'($urandom_range(1, 12)));
			else if (sel < 98)
				send_request(MODE_CONTAINS, s, 7'($urandom));
			else
				send_request(MODE_CLEAR, 16'($urandom), 7'($urandom));
		end
	endtask

	// Hold the receiver off while requests keep coming so the input stalls.
	task automatic test_backpressure();
		int n;
		fork
			begin
				hold_receiver = 1'b1;
				for (n = 0; n < 400; n++)
					@(negedge clk);
				hold_receiver = 1'b0;
			end
			test_random(12);
		join
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		hold_receiver = 1'b0;
		mismatch_count = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		pool_hw = 0;
		pool_cnt = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		wait_drained();
		test_free_list_full();
		wait_drained();
		test_backpressure();

		test_random(125);
		sender_idle_pct = 59;
		test_random(125);
		wait_drained();
		sender_idle_pct = 0;
		receiver_stall_pct = 59;
		test_random(125);
		sender_idle_pct = 13;
		receiver_stall_pct = 13;
		test_random(125);
		wait_drained();

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000000;
		$display("tb: failure");
		$finish;
	end

endmodule
